[rtl/rqwe_pkg.sv]
package rqwe_pkg;

    localparam int DEPTH  = 16;
    localparam int SEQ_W  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 5;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int S_DATA_W = ((SEQ_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SEQ_W + OCC_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT     = 2'd0,
        FUNC_ADVANCE    = 2'd1,
        FUNC_CLEAR      = 2'd2,
        FUNC_RESET_EDGE = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [SEQ_W-1:0]   key;
    } cell_ctrl_t;

endpackage

[rtl/reorder_queue_window_edge.sv]
// Channel  Direction  Handshake                 Payload
// s_       in         s_tvalid / s_tready       s_tuser = func, s_tdata = seq_num
// m_       out        m_tvalid / m_tready       m_tuser = status, m_tdata = left_edge, occupancy
// cfg_     in         cfg_valid / cfg_ready     cfg_data = max_gap
//
// Insert, clear and reset-edge results are in the output register on the cycle
// after the item is taken.
// Advance edge rotates the cell ring once around, examining the head cell at each
// step, then posts the result from the finish state once the output register is free.
// One item is in work at a time; s_tready also waits for the output register to
// be free, so a stalled m_ side holds the input side.
// aresetn clears the count, the edge, max_gap and the output valid; cell contents
// are not reset and are only read below the count.
module reorder_queue_window_edge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rqwe_pkg::S_DATA_W-1:0] s_tdata,  // [31:0] seq_num
    input  logic [rqwe_pkg::FUNC_W-1:0]   s_tuser,  // [1:0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rqwe_pkg::M_DATA_W-1:0] m_tdata,  // [31:0] left_edge, [36:32] occupancy
    output logic [rqwe_pkg::STAT_W-1:0]   m_tuser,  // [1:0] status
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rqwe_pkg::SEQ_W-1:0]    cfg_data
);

    rqwe_pkg::state_t           state_reg, state_next;
    logic [rqwe_pkg::IDX_W-1:0] step_reg, step_next;
    logic [rqwe_pkg::CNT_W-1:0] count_reg, count_next;
    logic [rqwe_pkg::SEQ_W-1:0] edge_reg, edge_next;
    logic [rqwe_pkg::SEQ_W-1:0] max_gap_reg;

    logic                       m_valid_reg, m_valid_next;
    rqwe_pkg::status_t          m_status_reg, m_status_next;
    logic [rqwe_pkg::SEQ_W-1:0] m_edge_reg, m_edge_next;
    logic [rqwe_pkg::OCC_W-1:0] m_occ_reg, m_occ_next;

    rqwe_pkg::cell_ctrl_t       ctrl;
    logic [rqwe_pkg::SEQ_W-1:0] head;
    logic                       dup;
    logic                       out_free;
    logic                       accept;
    logic                       load;
    rqwe_pkg::func_t            func;
    logic [rqwe_pkg::SEQ_W-1:0] limit;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == rqwe_pkg::ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign func      = rqwe_pkg::func_t'(s_tuser);
    assign cfg_ready = 1'b1;
    assign limit     = edge_reg + rqwe_pkg::SEQ_W'(1) + max_gap_reg;

    rqwe_chain u_chain (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .count (count_reg),
        .head  (head),
        .dup   (dup)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rqwe_pkg::ST_IDLE: begin
                if (accept && func == rqwe_pkg::FUNC_ADVANCE) begin
                    state_next = rqwe_pkg::ST_WALK;
                end
            end
            rqwe_pkg::ST_WALK: begin
                if (step_reg == rqwe_pkg::IDX_W'(rqwe_pkg::DEPTH - 1)) begin
                    state_next = rqwe_pkg::ST_FINISH;
                end
            end
            rqwe_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = rqwe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rqwe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl.op       = rqwe_pkg::CELL_HOLD;
        ctrl.key      = s_tdata[rqwe_pkg::SEQ_W-1:0];
        step_next     = step_reg;
        count_next    = count_reg;
        edge_next     = edge_reg;
        load          = 1'b0;
        m_status_next = rqwe_pkg::STAT_OK;
        case (state_reg)
            rqwe_pkg::ST_IDLE: begin
                if (accept) begin
                    load = 1'b1;
                    case (func)
                        rqwe_pkg::FUNC_INSERT: begin
                            if (dup) begin
                                m_status_next = rqwe_pkg::STAT_DUP;
                            end else if (count_reg == rqwe_pkg::CNT_W'(rqwe_pkg::DEPTH)) begin
                                m_status_next = rqwe_pkg::STAT_FULL;
                            end else begin
                                ctrl.op    = rqwe_pkg::CELL_INSERT;
                                count_next = count_reg + rqwe_pkg::CNT_W'(1);
                            end
                        end
                        rqwe_pkg::FUNC_ADVANCE: begin
                            load      = 1'b0;
                            step_next = '0;
                        end
                        rqwe_pkg::FUNC_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            edge_next = '0;
                        end
                    endcase
                end
            end
            rqwe_pkg::ST_WALK: begin
                // entries pass the head in ascending order, one per cycle
                ctrl.op   = rqwe_pkg::CELL_ROTATE;
                step_next = step_reg + rqwe_pkg::IDX_W'(1);
                if (rqwe_pkg::CNT_W'(step_reg) < count_reg && limit >= head) begin
                    edge_next = head;
                end
            end
            rqwe_pkg::ST_FINISH: begin
                load = out_free;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_edge_next  = m_edge_reg;
        m_occ_next   = m_occ_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_edge_next  = edge_next;
            m_occ_next   = rqwe_pkg::OCC_W'(count_next);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rqwe_pkg::ST_IDLE;
            step_reg    <= '0;
            count_reg   <= '0;
            edge_reg    <= '0;
            max_gap_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            count_reg   <= count_next;
            edge_reg    <= edge_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                max_gap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_status_reg <= m_status_next;
        end
        m_edge_reg <= m_edge_next;
        m_occ_reg  <= m_occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(rqwe_pkg::M_DATA_W - rqwe_pkg::SEQ_W - rqwe_pkg::OCC_W){1'b0}},
                       m_occ_reg, m_edge_reg};

endmodule

[rtl/rqwe_cell.sv]
module rqwe_cell (
    input  logic                      aclk,
    input  rqwe_pkg::cell_ctrl_t      ctrl,
    input  logic                      occ,
    input  logic [rqwe_pkg::SEQ_W-1:0] left_val,
    input  logic                      left_gt,
    input  logic [rqwe_pkg::SEQ_W-1:0] right_val,
    output logic [rqwe_pkg::SEQ_W-1:0] val,
    output logic                      gt,
    output logic                      eq
);

    logic [rqwe_pkg::SEQ_W-1:0] val_reg;
    logic [rqwe_pkg::SEQ_W-1:0] val_next;

    always_comb begin
        gt = occ && (val_reg > ctrl.key);
        eq = occ && (val_reg == ctrl.key);
    end

    always_comb begin
        val_next = val_reg;
        case (ctrl.op)
            rqwe_pkg::CELL_INSERT: begin
                // shift right once the left neighbor is above the key
                if (left_gt) begin
                    val_next = left_val;
                end else if (gt || !occ) begin
                    val_next = ctrl.key;
                end
            end
            rqwe_pkg::CELL_ROTATE: begin
                val_next = right_val;
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

[rtl/rqwe_chain.sv]
module rqwe_chain (
    input  logic                       aclk,
    input  rqwe_pkg::cell_ctrl_t       ctrl,
    input  logic [rqwe_pkg::CNT_W-1:0] count,
    output logic [rqwe_pkg::SEQ_W-1:0] head,
    output logic                       dup
);

    logic [rqwe_pkg::SEQ_W-1:0] val [rqwe_pkg::DEPTH];
    logic [rqwe_pkg::DEPTH-1:0] gt;
    logic [rqwe_pkg::DEPTH-1:0] eq;
    logic [rqwe_pkg::DEPTH-1:0] occ;

    for (genvar i = 0; i < rqwe_pkg::DEPTH; i++) begin : g_cell
        logic [rqwe_pkg::SEQ_W-1:0] left_val;
        logic                       left_gt;
        logic [rqwe_pkg::SEQ_W-1:0] right_val;

        assign occ[i] = rqwe_pkg::CNT_W'(i) < count;

        if (i == 0) begin : g_first
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end else begin : g_inner
            assign left_val = val[i-1];
            assign left_gt  = gt[i-1];
        end

        // the last cell closes the ring for the edge walk
        if (i == rqwe_pkg::DEPTH - 1) begin : g_last
            assign right_val = val[0];
        end else begin : g_mid
            assign right_val = val[i+1];
        end

        rqwe_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occ       (occ[i]),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .val       (val[i]),
            .gt        (gt[i]),
            .eq        (eq[i])
        );
    end

    assign head = val[0];
    assign dup  = |eq;

endmodule

[rtl/rqwe_checker.sv]
module rqwe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rqwe_pkg::M_DATA_W-1:0] m_tdata,
    input logic [rqwe_pkg::STAT_W-1:0]   m_tuser
);

    logic [rqwe_pkg::OCC_W-1:0] occ;
    assign occ = m_tdata[rqwe_pkg::SEQ_W +: rqwe_pkg::OCC_W];

    // a waiting result blocks the input side
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> occ <= rqwe_pkg::OCC_W'(rqwe_pkg::DEPTH))
        else $error("occupancy above depth");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rqwe_pkg::STAT_FULL
            |-> occ == rqwe_pkg::OCC_W'(rqwe_pkg::DEPTH))
        else $error("full status with room left");

    a_dup_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rqwe_pkg::STAT_DUP |-> occ != '0)
        else $error("duplicate status on empty queue");

endmodule

bind reorder_queue_window_edge rqwe_checker u_rqwe_checker (.*);

[sim/rqwe_tb_pkg.sv]
package rqwe_tb_pkg;

    import rqwe_pkg::*;

    typedef struct {
        status_t          status;
        logic [SEQ_W-1:0] left_edge;
        logic [OCC_W-1:0] occupancy;
    } queue_outcome_t;

    // Tracks the sorted sequence list and the window edge, queues the outcome of every
    // accepted operation and checks the block's outcomes against them in order.
    class reorder_window_tracker;

        logic [SEQ_W-1:0] held_seq [DEPTH];
        int               held_cnt;
        logic [SEQ_W-1:0] left_edge;
        logic [SEQ_W-1:0] max_gap;
        queue_outcome_t   outcomes [$];

        int mismatches;
        int checked;
        int inserts;
        int dups;
        int fulls;
        int advances;
        int edge_moves;
        int wraps;
        int gap_writes;

        function new();
            held_cnt   = 0;
            left_edge  = '0;
            max_gap    = '0;
            mismatches = 0;
            checked    = 0;
            inserts    = 0;
            dups       = 0;
            fulls      = 0;
            advances   = 0;
            edge_moves = 0;
            wraps      = 0;
            gap_writes = 0;
        endfunction

        function void set_gap(logic [SEQ_W-1:0] gap);
            max_gap = gap;
            gap_writes++;
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        function status_t insert_seq(logic [SEQ_W-1:0] v);
            int pos;
            pos = held_cnt;
            for (int i = 0; i < held_cnt; i++) begin
                if (held_seq[i] == v)
                    return STAT_DUP;
                if (held_seq[i] > v) begin
                    pos = i;
                    break;
                end
            end
            // duplicate check above wins over the full check
            if (held_cnt >= DEPTH)
                return STAT_FULL;
            for (int i = held_cnt; i > pos; i--)
                held_seq[i] = held_seq[i - 1];
            held_seq[pos] = v;
            held_cnt++;
            return STAT_OK;
        endfunction

        function void advance_edge();
            logic [SEQ_W-1:0] lim;
            for (int i = 0; i < held_cnt; i++) begin
                // the limit is recomputed from the edge as it moves, modulo 2^32
                lim = left_edge + 32'd1 + max_gap;
                if (lim < left_edge)
                    wraps++;
                if (lim >= held_seq[i]) begin
                    if (left_edge != held_seq[i])
                        edge_moves++;
                    left_edge = held_seq[i];
                end
            end
        endfunction

        function void note_op(func_t func, logic [SEQ_W-1:0] seq);
            queue_outcome_t o;
            o.status = STAT_OK;
            case (func)
                FUNC_INSERT: begin
                    inserts++;
                    o.status = insert_seq(seq);
                    if (o.status == STAT_DUP)
                        dups++;
                    if (o.status == STAT_FULL)
                        fulls++;
                end
                FUNC_ADVANCE: begin
                    advances++;
                    advance_edge();
                end
                FUNC_CLEAR:   held_cnt = 0;
                default:      left_edge = '0;
            endcase
            o.left_edge = left_edge;
            o.occupancy = held_cnt[OCC_W-1:0];
            outcomes = {outcomes, o};
        endfunction

        function void check_outcome(status_t status, logic [SEQ_W-1:0] edge_val,
                                    logic [OCC_W-1:0] occ);
            queue_outcome_t o;
            if (outcomes.size() == 0) begin
                $display("%0t: unexpected item: status %0d left_edge %h occupancy %0d",
                         $time, status, edge_val, occ);
                mismatches++;
                return;
            end
            o = outcomes.pop_front();
            checked++;
            if (status !== o.status) begin
                $display("%0t: status expected %0d actual %0d", $time, o.status, status);
                mismatches++;
            end
            if (edge_val !== o.left_edge) begin
                $display("%0t: left_edge expected %h actual %h", $time, o.left_edge, edge_val);
                mismatches++;
            end
            if (occ !== o.occupancy) begin
                $display("%0t: occupancy expected %0d actual %0d", $time, o.occupancy, occ);
                mismatches++;
            end
        endfunction

    endclass

endpackage

[sim/tb_top.sv]
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rqwe_pkg::*;
    import rqwe_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_ITEMS   = 170;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [FUNC_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SEQ_W-1:0]      cfg_data = '0;

    int send_idle = 0;
    int recv_idle = 0;
    int clear_pct = 8;
    logic [SEQ_W-1:0] window_base = '0;

    reorder_window_tracker sb;

    reorder_queue_window_edge dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("reorder_queue_window_edge: mismatch");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && sb != null) begin
            if (s_tvalid && s_tready)
                sb.note_op(func_t'(s_tuser), s_tdata[SEQ_W-1:0]);
            if (m_tvalid && m_tready)
                sb.check_outcome(status_t'(m_tuser), m_tdata[SEQ_W-1:0],
                                 m_tdata[SEQ_W +: OCC_W]);
        end
    end

    task automatic send_item(func_t func, logic [SEQ_W-1:0] seq);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= seq;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold the input side until every outcome is back and the block has settled
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_gap(logic [SEQ_W-1:0] gap);
        cfg_valid <= 1'b1;
        cfg_data  <= gap;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_gap(gap);
    endtask

    function automatic func_t pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58)
            return FUNC_INSERT;
        if (r < 83)
            return FUNC_ADVANCE;
        if (r < 83 + clear_pct)
            return FUNC_CLEAR;
        return FUNC_RESET_EDGE;
    endfunction

    function automatic logic [SEQ_W-1:0] pick_seq();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return $urandom;
            2, 3, 4: return window_base + $urandom_range(0, 23);
            5:       return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            6:       return $urandom_range(0, 23);
            default: return sb.left_edge + $urandom_range(0, 8);
        endcase
    endfunction

    initial begin
        logic [SEQ_W-1:0] gap;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty queue, duplicates, top value, fill to full, clear
        send_item(FUNC_RESET_EDGE, 32'hFFFF_FFFF);
        send_item(FUNC_ADVANCE, 32'h0);
        send_item(FUNC_INSERT, 32'h0);
        send_item(FUNC_INSERT, 32'h0);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF);
        send_item(FUNC_INSERT, 32'h1);
        send_item(FUNC_INSERT, 32'h2);
        send_item(FUNC_ADVANCE, 32'hAAAA_5555);
        for (int v = 3; v <= 14; v++)
            send_item(FUNC_INSERT, v);
        send_item(FUNC_INSERT, 32'd100);
        send_item(FUNC_INSERT, 32'd5);
        send_item(FUNC_ADVANCE, 32'h5555_AAAA);
        send_item(FUNC_CLEAR, 32'h0);
        send_item(FUNC_RESET_EDGE, 32'h0);

        for (int seg = 0; seg < 6; seg++) begin
            drain_results();
            case (seg)
                0:       gap = 32'hFFFF_FFFF;
                1:       gap = 32'h0;
                2:       gap = 32'd3;
                3:       gap = $urandom_range(0, 40);
                4:       gap = 32'h7FFF_FFFF;
                default: gap = 32'd1;
            endcase
            write_gap(gap);
            case (seg / 2)
                0: begin
                    send_idle = 38;
                    recv_idle = 56;
                end
                1: begin
                    send_idle = 56;
                    recv_idle = 38;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            clear_pct   = (seg % 2 == 0) ? 8 : 3;
            window_base = $urandom;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if (n == 60)
                    drain_results();
                send_item(pick_func(), pick_seq());
            end
        end
        drain_results();

        $display("checked %0d outcomes: %0d inserts (%0d duplicate, %0d full), %0d advances",
                 sb.checked, sb.inserts, sb.dups, sb.fulls, sb.advances);
        $display("edge moved %0d times, %0d wrapped limits, %0d gap settings",
                 sb.edge_moves, sb.wraps, sb.gap_writes);
        if (sb.mismatches == 0)
            $display("reorder_queue_window_edge: match");
        else
            $display("reorder_queue_window_edge: mismatch");
        $finish;
    end

endmodule
